// ----- hw/rtl/rtt_pkg.sv -----
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared types, constants and helpers of the TLS record tracker/truncator.
// ----------------------------------------------------------------------------
package rtt_pkg;

    localparam int FLOW_SLOTS = 1024;
    localparam int SLOT_W     = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
    localparam int SLOT_FIELD_W = 10;

    localparam logic [7:0] CT_CHANGE_CIPHER = 8'h14;
    localparam logic [7:0] CT_ALERT         = 8'h15;
    localparam logic [7:0] CT_HANDSHAKE     = 8'h16;
    localparam logic [7:0] CT_APP_DATA      = 8'h17;
    localparam logic [7:0] TLS_MAJOR        = 8'h03;
    localparam logic [4:0] HDR_BYTES        = 5'd5;
    localparam logic [2:0] HDR_LAST         = 3'd4;

    typedef enum logic [1:0] {
        DISP_NONE      = 2'd0,
        DISP_NO_APP    = 2'd1,
        DISP_MALFORMED = 2'd2,
        DISP_PREFIX    = 2'd3
    } disp_t;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    typedef enum logic {
        CFG_RECORD_KEEP       = 1'b0,
        CFG_CONTINUATION_KEEP = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic        command;
        logic [9:0]  flow_slot;
        logic [9:0]  reverse_slot;
        logic        is_tcp;
        logic        syn_or_rst;
        logic [31:0] tcp_sequence;
        logic [15:0] packet_length;
        logic [15:0] payload_start;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
        logic        last_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  disposition;
        logic [15:0] output_length;
    } out_item_t;

    typedef struct packed {
        logic        sync;
        logic        conf;
        logic        active;
        logic        constr;
        logic        seen;
        logic [31:0] exp_seq;
        logic [16:0] left;
    } flow_entry_t;

    typedef struct packed {
        logic open;
        logic cand;
        logic uncertain;
        logic norec;
        logic middle;
        logic resetdir;
        logic confsnap;
    } pkt_flags_t;

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
    } tbl_rd_t;

    typedef struct packed {
        logic              main_we;
        logic [SLOT_W-1:0] main_addr;
        flow_entry_t       main_data;
        logic              conf_we;
        logic [SLOT_W-1:0] conf_addr;
        logic              conf_data;
    } tbl_wr_t;

    typedef struct packed {
        disp_t       disp;
        logic        chk;
        logic [15:0] pkt_len;
        logic [15:0] pay_start;
        logic [15:0] pay_len;
        logic [15:0] cand;
    } res_t;

    // Reduces a slot field modulo the table depth by conditional subtraction.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_FIELD_W-1:0] x);
        logic [SLOT_FIELD_W-1:0] v;
        v = x;
        for (int k = SLOT_FIELD_W - 1; k >= 0; k--) begin
            if ((FLOW_SLOTS << k) < (1 << SLOT_FIELD_W)) begin
                if (int'(v) >= (FLOW_SLOTS << k)) begin
                    v = v - SLOT_FIELD_W'(FLOW_SLOTS << k);
                end
            end
        end
        return SLOT_W'(v);
    endfunction

endpackage

// ----- hw/rtl/tls_record_tracker_truncator.sv -----
// ----------------------------------------------------------------------------
// tls_record_tracker_truncator
// TLS record boundary tracker with per-direction flow table and truncation.
// ----------------------------------------------------------------------------
// The block takes one beat per cycle (a packet start or one payload byte)
// unless the clearing pass, a SYN/RST start or a stalled output holds it.
// A packet's result passes the input stage and output registers after the
// beat that ends it (the non-TCP, empty or oversized start, or the last
// payload byte). A SYN/RST start clears the reverse entry, then the flow
// entry, as each table memory has one write port. The synchronous flow
// table is read on any accepted beat; after reset no beat is accepted while
// all entries are cleared. Configuration writes are taken at any time.
module tls_record_tracker_truncator
    import rtt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] record_keep_reg;
    logic [15:0] continuation_keep_reg;

    tbl_rd_t     rd_req;
    tbl_wr_t     wr_req;
    flow_entry_t rd_entry;
    logic        table_busy;
    logic        res_valid;
    logic        res_ready;
    res_t        res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_keep_reg       <= '0;
            continuation_keep_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_RECORD_KEEP:       record_keep_reg       <= cfg_data;
                CFG_CONTINUATION_KEEP: continuation_keep_reg <= cfg_data;
                default:               record_keep_reg       <= record_keep_reg;
            endcase
        end
    end

    rtt_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_req   (rd_req),
        .wr_req   (wr_req),
        .rd_entry (rd_entry),
        .busy     (table_busy)
    );

    rtt_core u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .in_item           (in_item),
        .record_keep       (record_keep_reg),
        .continuation_keep (continuation_keep_reg),
        .table_busy        (table_busy),
        .rd_req            (rd_req),
        .rd_entry          (rd_entry),
        .wr_req            (wr_req),
        .res_valid         (res_valid),
        .res_ready         (res_ready),
        .res               (res)
    );

    rtt_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

// ----- hw/rtl/rtt_table.sv -----
// ----------------------------------------------------------------------------
// rtt_table
// Flow state memories: the per-direction entry and a separate confirmation
// bit array written for the reverse direction. Clears itself after reset.
// ----------------------------------------------------------------------------
module rtt_table
    import rtt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tbl_rd_t     rd_req,
    input  tbl_wr_t     wr_req,
    output flow_entry_t rd_entry,
    output logic        busy
);

    flow_entry_t main_mem [FLOW_SLOTS];
    logic        conf_mem [FLOW_SLOTS];

    flow_entry_t main_rd_reg;
    logic        conf_rd_reg;

    logic              clr_active_reg;
    logic              clr_active_next;
    logic [SLOT_W-1:0] clr_addr_reg;
    logic [SLOT_W-1:0] clr_addr_next;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == SLOT_W'(FLOW_SLOTS - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            main_mem[clr_addr_reg] <= '0;
        end
        else if (wr_req.main_we)
        begin
            main_mem[wr_req.main_addr] <= wr_req.main_data;
        end
        // A write to the entry being read in the same cycle is forwarded.
        if (rd_req.rd_en)
        begin
            if (wr_req.main_we && wr_req.main_addr == rd_req.rd_addr)
            begin
                main_rd_reg <= wr_req.main_data;
            end
            else
            begin
                main_rd_reg <= main_mem[rd_req.rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            conf_mem[clr_addr_reg] <= 1'b0;
        end
        else if (wr_req.conf_we)
        begin
            conf_mem[wr_req.conf_addr] <= wr_req.conf_data;
        end
        if (rd_req.rd_en)
        begin
            if (wr_req.conf_we && wr_req.conf_addr == rd_req.rd_addr)
            begin
                conf_rd_reg <= wr_req.conf_data;
            end
            else
            begin
                conf_rd_reg <= conf_mem[rd_req.rd_addr];
            end
        end
    end

    always_comb
    begin
        rd_entry      = main_rd_reg;
        rd_entry.conf = main_rd_reg.conf | conf_rd_reg;
    end

    assign busy = clr_active_reg;

endmodule

// ----- hw/rtl/rtt_core.sv -----
// ----------------------------------------------------------------------------
// rtt_core
// Packet and record parser. Holds the open packet's flow entry in a working
// register and writes it back to the table on every beat that touches it.
// ----------------------------------------------------------------------------
module rtt_core
    import rtt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    input  logic [15:0] record_keep,
    input  logic [15:0] continuation_keep,
    input  logic        table_busy,
    output tbl_rd_t     rd_req,
    input  flow_entry_t rd_entry,
    output tbl_wr_t     wr_req,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res
);

    logic     s1_valid_reg;
    logic     s1_valid_next;
    in_item_t s1_item_reg;
    logic     syn_done_reg;
    logic     syn_done_next;

    flow_entry_t       wk_reg,        wk_next;
    logic [SLOT_W-1:0] fslot_reg,     fslot_next;
    logic [SLOT_W-1:0] rslot_reg,     rslot_next;
    logic [31:0]       seq_reg,       seq_next;
    logic [15:0]       pkt_len_reg,   pkt_len_next;
    logic [15:0]       pay_start_reg, pay_start_next;
    logic [15:0]       pay_len_reg,   pay_len_next;
    pkt_flags_t        flags_reg,     flags_next;
    logic [39:0]       hdr_buf_reg,   hdr_buf_next;
    logic [2:0]        hdr_cnt_reg,   hdr_cnt_next;
    logic [15:0]       pos_reg,       pos_next;
    logic [15:0]       rbl_reg,       rbl_next;
    logic [15:0]       cand_reg,      cand_next;

    logic    accept;
    logic    emit;
    logic    syn_ph0;
    logic    s1_fire;
    tbl_wr_t wr_c;

    always_comb
    begin
        logic [SLOT_W-1:0] fs;
        logic [SLOT_W-1:0] rs;
        flow_entry_t       e;
        pkt_flags_t        f;
        logic [39:0]       hb;
        logic [7:0]        b;
        logic [7:0]        htype;
        logic [15:0]       skip;
        logic [15:0]       rec_len;
        logic [15:0]       o;
        logic [15:0]       avail;
        logic [16:0]       total;
        logic              fail;
        logic              done;
        logic              app;
        logic              fin;
        logic              keep_conf;
        logic              keep_seen;
        in_item_t          it;

        it      = s1_item_reg;
        fs      = slot_of(it.flow_slot);
        rs      = slot_of(it.reverse_slot);
        e       = wk_reg;
        f       = flags_reg;
        hb      = hdr_buf_reg;
        b       = it.data_byte;
        htype   = '0;
        rec_len = '0;
        o       = '0;
        avail   = '0;
        total   = '0;
        fail    = 1'b0;
        done    = 1'b0;
        app     = 1'b0;
        fin     = 1'b0;
        keep_conf = 1'b0;
        keep_seen = 1'b0;
        skip    = pay_len_reg - pos_reg - 16'd1;

        emit    = 1'b0;
        syn_ph0 = 1'b0;
        wr_c    = '0;
        res     = '0;

        wk_next        = wk_reg;
        fslot_next     = fslot_reg;
        rslot_next     = rslot_reg;
        seq_next       = seq_reg;
        pkt_len_next   = pkt_len_reg;
        pay_start_next = pay_start_reg;
        pay_len_next   = pay_len_reg;
        flags_next     = flags_reg;
        hdr_buf_next   = hdr_buf_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        pos_next       = pos_reg;
        rbl_next       = rbl_reg;
        cand_next      = cand_reg;

        if (s1_valid_reg && it.command == CMD_START)
        begin
            if (it.is_tcp && it.syn_or_rst && !syn_done_reg)
            begin
                // First phase of a SYN/RST start: clear the reverse entry; the flow entry follows.
                syn_ph0        = 1'b1;
                wr_c.main_we   = 1'b1;
                wr_c.main_addr = rs;
                wr_c.main_data = '0;
                wr_c.conf_we   = 1'b1;
                wr_c.conf_addr = rs;
                wr_c.conf_data = 1'b0;
            end
            else
            begin
                fslot_next     = fs;
                rslot_next     = rs;
                seq_next       = it.tcp_sequence;
                pkt_len_next   = it.packet_length;
                pay_start_next = it.payload_start;
                pay_len_next   = it.payload_length;
                flags_next     = '0;
                hdr_buf_next   = '0;
                hdr_cnt_next   = '0;
                pos_next       = '0;
                rbl_next       = '0;
                res.pkt_len    = it.packet_length;
                if (!it.is_tcp)
                begin
                    emit     = 1'b1;
                    res.disp = DISP_MALFORMED;
                end
                else
                begin
                    e = it.syn_or_rst ? flow_entry_t'('0) : rd_entry;
                    if (it.syn_or_rst)
                    begin
                        wr_c.main_we   = 1'b1;
                        wr_c.main_addr = fs;
                        wr_c.main_data = '0;
                        wr_c.conf_we   = 1'b1;
                        wr_c.conf_addr = fs;
                        wr_c.conf_data = 1'b0;
                    end
                    if (it.payload_length == 16'd0)
                    begin
                        emit     = 1'b1;
                        res.disp = DISP_NO_APP;
                    end
                    else if ((17'(it.payload_start) + 17'(it.payload_length))
                             > 17'(it.packet_length))
                    begin
                        emit     = 1'b1;
                        res.disp = DISP_MALFORMED;
                    end
                    else
                    begin
                        flags_next.open     = 1'b1;
                        flags_next.confsnap = e.conf;
                        if (e.sync && it.tcp_sequence != e.exp_seq)
                        begin
                            e.active  = 1'b0;
                            e.constr  = 1'b0;
                            e.left    = '0;
                            e.sync    = 1'b0;
                            e.exp_seq = '0;
                        end
                        cand_next = it.payload_length;
                        if (e.active)
                        begin
                            if (e.left > 17'(it.payload_length))
                            begin
                                flags_next.middle = e.constr;
                                e.left   = e.left - 17'(it.payload_length);
                                rbl_next = it.payload_length;
                            end
                            else if (e.left == 17'(it.payload_length))
                            begin
                                if (e.constr)
                                begin
                                    cand_next = (continuation_keep < it.payload_length)
                                              ? continuation_keep : it.payload_length;
                                    flags_next.cand = 1'b1;
                                end
                                rbl_next = it.payload_length;
                                e.active = 1'b0;
                                e.constr = 1'b0;
                                e.left   = '0;
                            end
                            else
                            begin
                                rbl_next = e.left[15:0];
                                if (e.constr)
                                begin
                                    flags_next.resetdir = 1'b1;
                                    rbl_next = it.payload_length;
                                end
                                e.active = 1'b0;
                                e.constr = 1'b0;
                                e.left   = '0;
                            end
                        end
                        wk_next        = e;
                        wr_c.main_we   = 1'b1;
                        wr_c.main_addr = fs;
                        wr_c.main_data = e;
                    end
                end
            end
        end
        else if (s1_valid_reg && f.open)
        begin
            if (rbl_reg != 16'd0)
            begin
                rbl_next = rbl_reg - 16'd1;
            end
            else
            begin
                case (hdr_cnt_reg)
                    3'd0:
                    begin
                        if ((17'(pos_reg) + 17'(HDR_BYTES)) > 17'(pay_len_reg) ||
                            !(b == CT_CHANGE_CIPHER || b == CT_ALERT ||
                              b == CT_HANDSHAKE || b == CT_APP_DATA))
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            hdr_buf_next = 40'(b);
                            hdr_cnt_next = 3'd1;
                        end
                    end
                    3'd1:
                    begin
                        if (b != TLS_MAJOR)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            hdr_buf_next = {hb[31:0], b};
                            hdr_cnt_next = 3'd2;
                        end
                    end
                    HDR_LAST:
                    begin
                        hdr_buf_next = {hb[31:0], b};
                        done = 1'b1;
                    end
                    default:
                    begin
                        hdr_buf_next = {hb[31:0], b};
                        hdr_cnt_next = hdr_cnt_reg + 3'd1;
                    end
                endcase
            end

            if (fail)
            begin
                if (!e.sync)
                begin
                    if (!f.confsnap)
                    begin
                        e = '0;
                    end
                    f.norec = 1'b1;
                end
                else
                begin
                    f.uncertain = 1'b1;
                end
                rbl_next     = skip;
                hdr_cnt_next = '0;
            end

            if (done)
            begin
                htype   = hdr_buf_next[39:32];
                rec_len = hdr_buf_next[15:0];
                o       = pos_reg - 16'd4;
                total   = 17'(rec_len) + 17'(HDR_BYTES);
                avail   = pay_len_reg - o;
                app     = (htype == CT_APP_DATA);
                hdr_cnt_next = '0;
                if (!e.sync && htype != CT_HANDSHAKE && !f.confsnap)
                begin
                    e        = '0;
                    f.norec  = 1'b1;
                    rbl_next = skip;
                end
                else
                begin
                    e.sync = 1'b1;
                    if (htype == CT_HANDSHAKE)
                    begin
                        e.conf         = 1'b1;
                        wr_c.conf_we   = 1'b1;
                        wr_c.conf_addr = rslot_reg;
                        wr_c.conf_data = 1'b1;
                    end
                    if (total > 17'(avail))
                    begin
                        if (app)
                        begin
                            e.seen    = 1'b1;
                            cand_next = o + ((record_keep < avail) ? record_keep : avail);
                            f.cand    = 1'b1;
                        end
                        e.active = 1'b1;
                        e.left   = total - 17'(avail);
                        e.constr = app;
                        rbl_next = skip;
                    end
                    else
                    begin
                        if (app)
                        begin
                            e.seen    = 1'b1;
                            cand_next = o + ((17'(record_keep) < total)
                                      ? record_keep : total[15:0]);
                            f.cand    = 1'b1;
                        end
                        rbl_next = rec_len;
                    end
                end
            end

            pos_next = pos_reg + 16'd1;
            fin      = (17'(pos_reg) + 17'd1) >= 17'(pay_len_reg);
            res.pkt_len   = pkt_len_reg;
            res.pay_start = pay_start_reg;
            res.pay_len   = pay_len_reg;
            res.cand      = cand_next;
            if (fin)
            begin
                emit = 1'b1;
                if (f.norec)
                begin
                    res.disp = DISP_NONE;
                end
                else
                begin
                    e.exp_seq = seq_reg + 32'(pay_len_reg);
                    if (f.resetdir)
                    begin
                        keep_conf = e.conf;
                        keep_seen = e.seen;
                        e = '0;
                        if (keep_conf)
                        begin
                            e.conf = 1'b1;
                            e.seen = keep_seen;
                        end
                        res.disp = DISP_NO_APP;
                    end
                    else if (f.uncertain)
                    begin
                        res.disp = DISP_MALFORMED;
                    end
                    else if (f.middle)
                    begin
                        res.disp = DISP_NO_APP;
                    end
                    else
                    begin
                        res.disp = e.sync ? DISP_NO_APP : DISP_NONE;
                        res.chk  = e.sync && f.cand;
                    end
                end
                f = '0;
            end
            flags_next     = f;
            wk_next        = e;
            wr_c.main_we   = 1'b1;
            wr_c.main_addr = fslot_reg;
            wr_c.main_data = e;
        end
    end

    assign s1_fire   = s1_valid_reg && !syn_ph0 && !(emit && !res_ready);
    assign in_ready  = !table_busy && (!s1_valid_reg || s1_fire);
    assign accept    = in_valid && in_ready;
    assign res_valid = s1_fire && emit;
    assign wr_req    = (s1_fire || syn_ph0) ? wr_c : tbl_wr_t'('0);

    assign rd_req.rd_en   = accept;
    assign rd_req.rd_addr = slot_of(in_item.flow_slot);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        syn_done_next = syn_done_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            syn_done_next = 1'b0;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else if (syn_ph0)
        begin
            syn_done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            syn_done_reg <= 1'b0;
            flags_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            syn_done_reg <= syn_done_next;
            if (s1_fire)
            begin
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= in_item;
        end
        if (s1_fire)
        begin
            wk_reg        <= wk_next;
            fslot_reg     <= fslot_next;
            rslot_reg     <= rslot_next;
            seq_reg       <= seq_next;
            pkt_len_reg   <= pkt_len_next;
            pay_start_reg <= pay_start_next;
            pay_len_reg   <= pay_len_next;
            hdr_buf_reg   <= hdr_buf_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            pos_reg       <= pos_next;
            rbl_reg       <= rbl_next;
            cand_reg      <= cand_next;
        end
    end

endmodule

// ----- hw/rtl/rtt_out.sv -----
// ----------------------------------------------------------------------------
// rtt_out
// Result register. Holds one pending result and resolves the prefix length.
// ----------------------------------------------------------------------------
module rtt_out
    import rtt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      res_valid,
    output logic      res_ready,
    input  res_t      res,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic out_valid_reg;
    logic out_valid_next;
    res_t res_reg;

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            res_reg <= res;
        end
    end

    // An application data prefix is reported only when it is shorter than the payload.
    always_comb
    begin
        if (res_reg.chk && res_reg.cand < res_reg.pay_len)
        begin
            out_item.disposition   = DISP_PREFIX;
            out_item.output_length = res_reg.pay_start + res_reg.cand;
        end
        else
        begin
            out_item.disposition   = res_reg.disp;
            out_item.output_length = res_reg.pkt_len;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hw/rtl/rtt_checker.sv -----
// ----------------------------------------------------------------------------
// rtt_checker
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module rtt_checker
    import rtt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    // A result beat waiting for the sink holds still.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result beat changed while stalled");

    // The table clearing pass keeps the input closed right after reset.
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !in_ready)
        else $error("input open during table clearing");

    // With no input beats and a free sink, the pipeline drains.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_ready, 1) && $past(out_ready, 2) && $past(out_ready, 3) &&
        !$past(in_valid && in_ready, 1) && !$past(in_valid && in_ready, 2) &&
        !$past(in_valid && in_ready, 3) |-> !out_valid)
        else $error("result appeared with no input beat in flight");

endmodule

bind tls_record_tracker_truncator rtt_checker u_rtt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

// ----- tb/sv/tls_record_tracker_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tls_record_tracker_checker
// Watches the input, output and configuration channels of the TLS record
// tracker, keeps its own copy of the flow table and packet state, predicts
// the disposition and kept length of every packet and compares each output
// beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tls_record_tracker_checker
    import rtt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_item_t    in_item,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_item_t   out_item,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          failures,
    output int          pending
);

    flow_entry_t flows [FLOW_SLOTS];
    logic [39:0] hdr;
    int unsigned hdr_cnt;
    int unsigned pay_pos;
    int unsigned skip_left;
    int unsigned cand_size;
    bit          f_open, f_cand, f_unc, f_norec, f_mid, f_rdir, f_conf;
    logic [31:0] m_seq;
    int unsigned m_pkt_len, m_pay_start, m_pay_len;
    int          m_fs, m_rs;
    int unsigned keep_rec, keep_cont;
    out_item_t   verdict_q [$];
    int          fail_cnt;

    function automatic int unsigned min_u(int unsigned a, int unsigned b);
        return (a < b) ? a : b;
    endfunction

    function automatic void push_verdict(disp_t d, int unsigned len);
        out_item_t r;
        r.disposition   = d;
        r.output_length = len[15:0];
        verdict_q.push_back(r);
    endfunction

    function automatic void clear_flags();
        {f_open, f_cand, f_unc, f_norec, f_mid, f_rdir, f_conf} = '0;
    endfunction

    function automatic void clear_active(int s);
        flows[s].active = 1'b0;
        flows[s].constr = 1'b0;
        flows[s].left   = '0;
    endfunction

    function automatic void skip_rest(int unsigned pos);
        skip_left = m_pay_len - pos - 1;
        hdr_cnt   = 0;
    endfunction

    function automatic void header_fail(int unsigned pos);
        if (!flows[m_fs].sync) begin
            if (!f_conf)
                flows[m_fs] = '0;
            f_norec = 1'b1;
        end
        else
            f_unc = 1'b1;
        skip_rest(pos);
    endfunction

    function automatic void header_done(int unsigned pos);
        int unsigned o, len, total, avail;
        logic [7:0]  ctype;
        bit          app;
        o     = pos - 4;
        ctype = hdr[39:32];
        len   = hdr[15:0];
        total = 5 + len;
        avail = m_pay_len - o;
        app   = (ctype == CT_APP_DATA);
        if (!flows[m_fs].sync && ctype != CT_HANDSHAKE && !f_conf) begin
            flows[m_fs] = '0;
            f_norec = 1'b1;
            skip_rest(pos);
            return;
        end
        flows[m_fs].sync = 1'b1;
        if (ctype == CT_HANDSHAKE) begin
            flows[m_fs].conf = 1'b1;
            flows[m_rs].conf = 1'b1;
        end
        if (total > avail) begin
            if (app) begin
                flows[m_fs].seen = 1'b1;
                cand_size = o + min_u(keep_rec, avail);
                f_cand = 1'b1;
            end
            flows[m_fs].active = 1'b1;
            flows[m_fs].left   = 17'(total - avail);
            flows[m_fs].constr = app;
            skip_rest(pos);
            return;
        end
        if (app) begin
            flows[m_fs].seen = 1'b1;
            cand_size = o + min_u(keep_rec, total);
            f_cand = 1'b1;
        end
        skip_left = len;
        hdr_cnt   = 0;
    endfunction

    function automatic void close_packet();
        bit norec, rdir, unc, mid, cand, c, s;
        norec = f_norec; rdir = f_rdir; unc = f_unc; mid = f_mid; cand = f_cand;
        clear_flags();
        if (norec) begin
            push_verdict(DISP_NONE, m_pkt_len);
            return;
        end
        flows[m_fs].exp_seq = m_seq + 32'(m_pay_len);
        if (rdir) begin
            c = flows[m_fs].conf;
            s = flows[m_fs].seen;
            flows[m_fs] = '0;
            if (c) begin
                flows[m_fs].conf = 1'b1;
                flows[m_fs].seen = s;
            end
            push_verdict(DISP_NO_APP, m_pkt_len);
        end
        else if (unc)
            push_verdict(DISP_MALFORMED, m_pkt_len);
        else if (mid)
            push_verdict(DISP_NO_APP, m_pkt_len);
        else if (!flows[m_fs].sync || !cand || cand_size >= m_pay_len)
            push_verdict(flows[m_fs].sync ? DISP_NO_APP : DISP_NONE, m_pkt_len);
        else
            push_verdict(DISP_PREFIX, m_pay_start + cand_size);
    endfunction

    function automatic void track_start(in_item_t it);
        int unsigned rem;
        clear_flags();
        hdr = '0; hdr_cnt = 0; pay_pos = 0; skip_left = 0;
        m_fs        = int'(it.flow_slot) % FLOW_SLOTS;
        m_rs        = int'(it.reverse_slot) % FLOW_SLOTS;
        m_seq       = it.tcp_sequence;
        m_pkt_len   = it.packet_length;
        m_pay_start = it.payload_start;
        m_pay_len   = it.payload_length;
        if (!it.is_tcp) begin
            push_verdict(DISP_MALFORMED, m_pkt_len);
            return;
        end
        if (it.syn_or_rst) begin
            flows[m_fs] = '0;
            flows[m_rs] = '0;
        end
        if (m_pay_len == 0) begin
            push_verdict(DISP_NO_APP, m_pkt_len);
            return;
        end
        if (m_pay_start + m_pay_len > m_pkt_len) begin
            push_verdict(DISP_MALFORMED, m_pkt_len);
            return;
        end
        f_open = 1'b1;
        f_conf = flows[m_fs].conf;
        if (flows[m_fs].sync && m_seq != flows[m_fs].exp_seq) begin
            clear_active(m_fs);
            flows[m_fs].sync    = 1'b0;
            flows[m_fs].exp_seq = '0;
        end
        cand_size = m_pay_len;
        if (flows[m_fs].active) begin
            rem = flows[m_fs].left;
            if (rem > m_pay_len) begin
                if (flows[m_fs].constr)
                    f_mid = 1'b1;
                flows[m_fs].left = 17'(rem - m_pay_len);
                skip_left = m_pay_len;
            end
            else if (rem == m_pay_len) begin
                if (flows[m_fs].constr) begin
                    cand_size = min_u(keep_cont, m_pay_len);
                    f_cand = 1'b1;
                end
                skip_left = m_pay_len;
                clear_active(m_fs);
            end
            else begin
                skip_left = rem;
                if (flows[m_fs].constr) begin
                    f_rdir = 1'b1;
                    skip_left = m_pay_len;
                end
                clear_active(m_fs);
            end
        end
    endfunction

    function automatic void track_byte(logic [7:0] b);
        int unsigned pos;
        if (!f_open)
            return;
        pos = pay_pos;
        if (skip_left != 0)
            skip_left--;
        else begin
            case (hdr_cnt)
                0: begin
                    if (pos + 5 > m_pay_len || !(b inside {CT_CHANGE_CIPHER, CT_ALERT,
                                                           CT_HANDSHAKE, CT_APP_DATA}))
                        header_fail(pos);
                    else begin
                        hdr = 40'(b);
                        hdr_cnt = 1;
                    end
                end
                1: begin
                    if (b != TLS_MAJOR)
                        header_fail(pos);
                    else begin
                        hdr = {hdr[31:0], b};
                        hdr_cnt = 2;
                    end
                end
                4: begin
                    hdr = {hdr[31:0], b};
                    header_done(pos);
                end
                default: begin
                    hdr = {hdr[31:0], b};
                    hdr_cnt++;
                end
            endcase
        end
        pay_pos = pos + 1;
        if (pay_pos >= m_pay_len)
            close_packet();
    endfunction

    always @(posedge clk or negedge rst_n) begin
        out_item_t want;
        if (!rst_n) begin
            for (int i = 0; i < FLOW_SLOTS; i++)
                flows[i] = '0;
            clear_flags();
            hdr = '0; hdr_cnt = 0; pay_pos = 0; skip_left = 0; cand_size = 0;
            m_seq = '0; m_pkt_len = 0; m_pay_start = 0; m_pay_len = 0;
            m_fs = 0; m_rs = 0;
            keep_rec = 0; keep_cont = 0;
            verdict_q.delete();
            fail_cnt = 0;
            failures <= 0;
            pending  <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("unexpected output beat: disposition %0d length %0d",
                           out_item.disposition, out_item.output_length);
                    fail_cnt++;
                end
                else begin
                    want = verdict_q.pop_front();
                    if (out_item.disposition !== want.disposition) begin
                        $error("disposition: expected %0d, got %0d",
                               want.disposition, out_item.disposition);
                        fail_cnt++;
                    end
                    if (out_item.output_length !== want.output_length) begin
                        $error("output_length: expected %0d, got %0d",
                               want.output_length, out_item.output_length);
                        fail_cnt++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                if (in_item.command == CMD_BYTE)
                    track_byte(in_item.data_byte);
                else
                    track_start(in_item);
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_RECORD_KEEP)
                    keep_rec = cfg_data;
                else
                    keep_cont = cfg_data;
            end
            failures <= fail_cnt;
            pending  <= verdict_q.size();
        end
    end

endmodule

// ----- tb/sv/tls_record_tracker_truncator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tls_record_tracker_truncator_tb
// Drives packets of TLS records, broken streams and noise into the tracker
// under several keep-length settings, with bursty input and a stalling
// output, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tls_record_tracker_truncator_tb;
    import rtt_pkg::*;

    localparam int LIMIT = 600000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;
    int          failures;
    int          pending;
    int          cycles;
    int          stall_cnt;
    int          burst_left;
    int          beats_sent;
    logic [31:0] next_seq [FLOW_SLOTS];
    int          carry [FLOW_SLOTS];

    tls_record_tracker_truncator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tls_record_tracker_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .pending   (pending)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // The receiver alternates between a fully open window and random stalls,
    // with an occasional long stall.
    always @(posedge clk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt[9:4] == 6'd0)
            out_ready <= 1'b0;
        else if (stall_cnt[8])
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 2) != 0);
    end

    task automatic put(in_item_t it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        beats_sent++;
    endtask

    function automatic in_item_t start_beat(int fs, int rs, bit tcp, bit syn,
                                            logic [31:0] seq, int plen, int pst, int plg);
        in_item_t it;
        it = {$urandom, $urandom, $urandom, $urandom};
        it.command        = CMD_START;
        it.flow_slot      = fs[9:0];
        it.reverse_slot   = rs[9:0];
        it.is_tcp         = tcp;
        it.syn_or_rst     = syn;
        it.tcp_sequence   = seq;
        it.packet_length  = plen[15:0];
        it.payload_start  = pst[15:0];
        it.payload_length = plg[15:0];
        return it;
    endfunction

    function automatic in_item_t data_beat(logic [7:0] b, bit last);
        in_item_t it;
        it = {$urandom, $urandom, $urandom, $urandom};
        it.command   = CMD_BYTE;
        it.data_byte = b;
        it.last_byte = last;
        return it;
    endfunction

    // Sends one packet; a cut below the payload size abandons it midway.
    task automatic send_packet(int fs, int rs, bit syn, logic [31:0] seq,
                               logic [7:0] pay [$], int cut);
        int pst, plen;
        bit last;
        pst  = $urandom_range(14, 60);
        plen = pst + pay.size() + $urandom_range(0, 10);
        put(start_beat(fs, rs, 1'b1, syn, seq, plen, pst, pay.size()));
        for (int i = 0; i < pay.size() && i < cut; i++) begin
            last = (i == pay.size() - 1);
            if ($urandom_range(0, 9) == 0)
                last = ~last;
            put(data_beat(pay[i], last));
        end
    endtask

    // Builds the next piece of a flow's record stream.
    task automatic stream_packet(int fs, int rs, bit syn, bit garbage, int cut);
        logic [7:0] pay [$];
        int target, len;
        logic [7:0] ctype;
        if (syn) begin
            carry[fs] = 0;
            carry[rs] = 0;
        end
        case ($urandom_range(0, 49))
            0:       target = $urandom_range(600, 1500);
            1, 2, 3: target = $urandom_range(0, 4);
            default: target = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 300)
                                                            : $urandom_range(1, 60);
        endcase
        while (pay.size() < target) begin
            if (garbage)
                pay.push_back($urandom);
            else if (carry[fs] > 0) begin
                pay.push_back($urandom);
                carry[fs]--;
            end
            else if (target - pay.size() < 5)
                break;
            else begin
                case ($urandom_range(0, 9))
                    0:       ctype = CT_CHANGE_CIPHER;
                    1:       ctype = CT_ALERT;
                    2, 3, 4: ctype = CT_HANDSHAKE;
                    default: ctype = CT_APP_DATA;
                endcase
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400)
                                                  : $urandom_range(0, 40);
                pay.push_back(ctype);
                pay.push_back(TLS_MAJOR);
                pay.push_back($urandom_range(0, 4));
                pay.push_back(len[15:8]);
                pay.push_back(len[7:0]);
                carry[fs] = len;
            end
        end
        send_packet(fs, rs, syn, next_seq[fs], pay, cut);
        next_seq[fs] += pay.size();
        if (garbage || cut < pay.size())
            carry[fs] = 0;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_slot();
        case ($urandom_range(0, 9))
            0:       return 1023;
            1:       return $urandom_range(0, 1023);
            default: return $urandom_range(0, 5);
        endcase
    endfunction

    initial begin
        logic [7:0] pay [$];
        int fs, rs, sel, phase_end;
        logic [15:0] rec_keep [5];
        logic [15:0] cont_keep [5];

        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_RECORD_KEEP;
        cfg_data = '0;
        cycles = 0;
        stall_cnt = 0;
        burst_left = 0;
        beats_sent = 0;
        for (int i = 0; i < FLOW_SLOTS; i++) begin
            next_seq[i] = $urandom;
            carry[i] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        write_reg(CFG_RECORD_KEEP, 16'hFFFF);
        write_reg(CFG_CONTINUATION_KEEP, 16'h0000);
        put(start_beat(1023, 1023, 1'b0, 1'b1, 32'hFFFF_FFFF, 65535, 65535, 65535));
        put(start_beat(7, 8, 1'b1, 1'b1, 32'h0, 0, 0, 0));
        put(start_beat(9, 9, 1'b1, 1'b0, 32'h8000_0000, 65535, 65535, 65535));
        pay = '{CT_HANDSHAKE, TLS_MAJOR, 8'h03, 8'h00, 8'h02, 8'hAA, 8'h55};
        send_packet(1, 2, 1'b0, 32'd100, pay, 99);
        pay = '{CT_APP_DATA, TLS_MAJOR, 8'h03, 8'h00, 8'h0A, 8'h01, 8'h02, 8'h03};
        send_packet(1, 2, 1'b0, 32'd107, pay, 99);
        pay = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77};
        send_packet(1, 2, 1'b0, 32'd115, pay, 99);
        put(data_beat(8'hFF, 1'b1));
        pay = '{8'h99, 8'h03, 8'h03, 8'h00, 8'h00};
        send_packet(3, 4, 1'b0, 32'd5, pay, 99);

        rec_keep  = '{16'h0000, 16'hFFFF, 16'($urandom_range(0, 40)),
                      16'($urandom_range(0, 40)), 16'($urandom_range(1, 8))};
        cont_keep = '{16'h0000, 16'hFFFF, 16'($urandom_range(0, 40)),
                      16'($urandom_range(0, 40)), 16'($urandom_range(1, 8))};
        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_RECORD_KEEP, rec_keep[ph]);
                write_reg(CFG_CONTINUATION_KEEP, cont_keep[ph]);
            end
            else begin
                write_reg(CFG_CONTINUATION_KEEP, cont_keep[ph]);
                write_reg(CFG_RECORD_KEEP, rec_keep[ph]);
            end
            phase_end = beats_sent + 150;
            while (beats_sent < phase_end) begin
                fs  = pick_slot();
                rs  = ($urandom_range(0, 9) == 0) ? fs : (fs ^ 1);
                sel = $urandom_range(0, 99);
                if (sel < 70)
                    stream_packet(fs, rs, 1'b0, 1'b0, 1 << 20);
                else if (sel < 76)
                    stream_packet(fs, rs, 1'b1, 1'b0, 1 << 20);
                else if (sel < 82) begin
                    next_seq[fs] += $urandom_range(1, 1000);
                    carry[fs] = 0;
                    stream_packet(fs, rs, 1'b0, 1'b0, 1 << 20);
                end
                else if (sel < 86)
                    put(start_beat(fs, rs, 1'b0, $urandom, $urandom, $urandom,
                                   $urandom, $urandom));
                else if (sel < 90)
                    put(start_beat(fs, rs, 1'b1, $urandom_range(0, 1), $urandom,
                                   $urandom_range(0, 100), $urandom_range(50, 65535),
                                   $urandom_range(60, 65535)));
                else if (sel < 94)
                    stream_packet(fs, rs, 1'b0, 1'b0, $urandom_range(0, 8));
                else if (sel < 97)
                    put(data_beat($urandom, $urandom));
                else
                    stream_packet(fs, rs, 1'b0, 1'b1, 1 << 20);
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/rtt_pkg.sv
hw/rtl/rtt_table.sv
hw/rtl/rtt_core.sv
hw/rtl/rtt_out.sv
hw/rtl/tls_record_tracker_truncator.sv
hw/rtl/rtt_checker.sv
tb/sv/tls_record_tracker_checker.sv
tb/sv/tls_record_tracker_truncator_tb.sv
